// ===== rtl/aec_pkg.sv =====
// shared constants, types and register codes for the auto exposure controller
package aec_pkg;

  localparam int SAMPLE_COUNT_LOG2 = 10;

  localparam int SAMPLE_W   = 8;
  localparam int EXPOSURE_W = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int FRAME_W    = 7;
  localparam int STEP_W     = 10;
  localparam int ADDR_W     = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LEVEL       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLACK_LEVEL        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_LOG2        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPOSURE_MIN       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPOSURE_MAX       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION_LEVEL   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION_MAX_PCT = 3'd6;

  // register reset values
  localparam logic [7:0]            TARGET_LEVEL_RESET     = 8'd100;
  localparam logic [7:0]            BLACK_LEVEL_RESET      = 8'd16;
  localparam logic [2:0]            PERIOD_LOG2_RESET      = 3'd2;
  localparam logic [EXPOSURE_W-1:0] EXPOSURE_MIN_RESET     = 12'd16;
  localparam logic [EXPOSURE_W-1:0] EXPOSURE_MAX_RESET     = 12'd1180;
  localparam logic [7:0]            SATURATION_LEVEL_RESET = 8'd250;
  localparam logic [6:0]            SATURATION_PCT_RESET   = 7'd2;
  localparam logic [EXPOSURE_W-1:0] EXPOSURE_RESET         = 12'h46B;

  // sensor registers
  localparam logic [ADDR_W-1:0] REG_HOLD   = 16'h0104;
  localparam logic [ADDR_W-1:0] REG_EXP_HI = 16'h0202;
  localparam logic [ADDR_W-1:0] REG_EXP_LO = 16'h0203;

  // control law constants
  localparam int PERCENT_SCALE  = 100;
  localparam int HIGHLIGHT_GAIN = 160;
  localparam int HIGHLIGHT_BASE = 16;
  localparam int STEP_LIMIT     = 32;

  // words of a group-hold write sequence
  localparam logic [1:0] WORD_HOLD_SET   = 2'd0;
  localparam logic [1:0] WORD_EXP_HI     = 2'd1;
  localparam logic [1:0] WORD_EXP_LO     = 2'd2;
  localparam logic [1:0] WORD_HOLD_CLEAR = 2'd3;

  typedef struct packed {
    logic [7:0]            target_level;
    logic [7:0]            black_level;
    logic [2:0]            period_log2;
    logic [EXPOSURE_W-1:0] exposure_min;
    logic [EXPOSURE_W-1:0] exposure_max;
    logic [7:0]            saturation_level;
    logic [6:0]            saturation_max_percent;
  } cfg_t;

  typedef struct packed {
    logic                add;
    logic                frame_end;
    logic [SAMPLE_W-1:0] sample;
  } accum_ctl_t;

endpackage

// ===== rtl/aec_in_if.sv =====
// input channel: grid samples and frame-end events
interface aec_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink (input valid, input action, input sample, output ready);
endinterface

// ===== rtl/aec_out_if.sv =====
// output channel: sensor register writes and status words
interface aec_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [15:0] reg_address;
  logic [7:0]  reg_value;
  logic [11:0] exposure;
  logic        last;

  modport source (output valid, output write_valid, output reg_address, output reg_value,
                  output exposure, output last, input ready);
  modport sink (input valid, input write_valid, input reg_address, input reg_value,
                input exposure, input last, output ready);
endinterface

// ===== rtl/aec_accum.sv =====
// frame statistics: saturating sample sum, clipped sample count, frame counter
module aec_accum #(
  parameter int SAMPLE_COUNT_LOG2 = aec_pkg::SAMPLE_COUNT_LOG2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  aec_pkg::accum_ctl_t          ctl,
  input  aec_pkg::cfg_t                cfg,
  output logic [SAMPLE_COUNT_LOG2+7:0] sum,
  output logic [SAMPLE_COUNT_LOG2:0]   sat,
  output logic                         update_due
);

  localparam int SUM_W = SAMPLE_COUNT_LOG2 + 8;
  localparam int CNT_W = SAMPLE_COUNT_LOG2 + 1;

  logic [SUM_W:0]                  sum_wide;
  logic [SUM_W-1:0]                sum_next;
  logic [CNT_W-1:0]                sat_next;
  logic [aec_pkg::FRAME_W-1:0]     frame_counter;
  logic [aec_pkg::FRAME_W-1:0]     frame_counter_next;
  logic [aec_pkg::FRAME_W-1:0]     period_mask;

  always_comb begin
    sum_wide = {1'b0, sum} + (SUM_W + 1)'(ctl.sample);
    sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    sat_next = sat;
    if (ctl.sample >= cfg.saturation_level && sat != {CNT_W{1'b1}}) begin
      sat_next = sat + CNT_W'(1);
    end
    frame_counter_next = frame_counter + aec_pkg::FRAME_W'(1);
    period_mask = ~({aec_pkg::FRAME_W{1'b1}} << cfg.period_log2);
    update_due = (frame_counter_next & period_mask) == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      sat <= '0;
      frame_counter <= '0;
    end else if (ctl.frame_end) begin
      sum <= '0;
      sat <= '0;
      frame_counter <= frame_counter_next;
    end else if (ctl.add) begin
      sum <= sum_next;
      sat <= sat_next;
    end
  end

endmodule

// ===== rtl/aec_update.sv =====
// proportional exposure step with highlight override and limit clamp
module aec_update #(
  parameter int SAMPLE_COUNT_LOG2 = aec_pkg::SAMPLE_COUNT_LOG2
) (
  input  logic [SAMPLE_COUNT_LOG2+7:0]        sum,
  input  logic [SAMPLE_COUNT_LOG2:0]          sat,
  input  aec_pkg::cfg_t                       cfg,
  input  logic [aec_pkg::EXPOSURE_W-1:0]      exposure,
  output logic [aec_pkg::EXPOSURE_W-1:0]      exposure_next,
  output logic                                changed
);

  localparam int N       = SAMPLE_COUNT_LOG2;
  localparam int CNT_W   = N + 1;
  localparam int SCALE_W = N + 8;
  localparam int GAIN_W  = N + 9;
  localparam int STEP_W  = aec_pkg::STEP_W;
  localparam int EXP_W   = aec_pkg::EXPOSURE_W;
  localparam int E_W     = EXP_W + 2;

  logic [7:0]                mean;
  logic [8:0]                level_diff;
  logic [7:0]                level;
  logic signed [9:0]         err;
  logic signed [STEP_W-1:0]  step_raw;
  logic signed [STEP_W-1:0]  step;
  logic signed [STEP_W-1:0]  down;
  logic signed [STEP_W-1:0]  step_final;
  logic [SCALE_W-1:0]        sat_scaled;
  logic [SCALE_W-1:0]        pct_scaled;
  logic                      highlight;
  logic [GAIN_W-1:0]         sat_gain;
  logic [8:0]                gain_hi;
  logic signed [E_W-1:0]     e_sum;
  logic signed [E_W-1:0]     e_min;
  logic signed [E_W-1:0]     e_clamped;

  always_comb begin
    mean = sum[N+7:N];
    level_diff = {1'b0, mean} - {1'b0, cfg.black_level};
    level = level_diff[8] ? 8'd0 : level_diff[7:0];
    err = $signed({2'b00, cfg.target_level}) - $signed({2'b00, level});
    step_raw = STEP_W'(err >>> 3);
    step = step_raw;
    if (step_raw > $signed(STEP_W'(aec_pkg::STEP_LIMIT))) begin
      step = STEP_W'(aec_pkg::STEP_LIMIT);
    end else if (step_raw < -$signed(STEP_W'(aec_pkg::STEP_LIMIT))) begin
      step = -$signed(STEP_W'(aec_pkg::STEP_LIMIT));
    end

    sat_scaled = SCALE_W'(sat) * SCALE_W'(aec_pkg::PERCENT_SCALE);
    pct_scaled = SCALE_W'({cfg.saturation_max_percent, {N{1'b0}}});
    highlight = sat_scaled > pct_scaled;
    sat_gain = GAIN_W'(sat) * GAIN_W'(aec_pkg::HIGHLIGHT_GAIN);
    gain_hi = sat_gain[N+8:N];
    down = -$signed(STEP_W'(aec_pkg::HIGHLIGHT_BASE) + {1'b0, gain_hi});
    step_final = (highlight && down < step) ? down : step;

    e_sum = $signed({2'b00, exposure}) + E_W'(step_final);
    e_min = (e_sum < $signed({2'b00, cfg.exposure_min})) ?
            $signed({2'b00, cfg.exposure_min}) : e_sum;
    e_clamped = (e_min > $signed({2'b00, cfg.exposure_max})) ?
                $signed({2'b00, cfg.exposure_max}) : e_min;
    exposure_next = e_clamped[EXP_W-1:0];
    changed = exposure_next != exposure;
  end

endmodule

// ===== rtl/aec_seq.sv =====
// output sequencer: one status word or a four-word group-hold write sequence
module aec_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           start_write,
  input  logic [aec_pkg::EXPOSURE_W-1:0] exposure,
  output logic                           can_load,
  aec_out_if.source                      results
);

  logic       busy;
  logic       is_write;
  logic [1:0] word_index;
  logic       word_last;

  always_comb begin
    word_last = !is_write || word_index == aec_pkg::WORD_HOLD_CLEAR;
    can_load = !busy || (results.ready && word_last);

    results.valid = busy;
    results.write_valid = is_write;
    results.exposure = exposure;
    results.last = word_last;
    results.reg_address = '0;
    results.reg_value = '0;
    if (is_write) begin
      unique case (word_index)
        aec_pkg::WORD_HOLD_SET: begin
          results.reg_address = aec_pkg::REG_HOLD;
          results.reg_value = 8'd1;
        end
        aec_pkg::WORD_EXP_HI: begin
          results.reg_address = aec_pkg::REG_EXP_HI;
          results.reg_value = 8'(exposure[aec_pkg::EXPOSURE_W-1:8]);
        end
        aec_pkg::WORD_EXP_LO: begin
          results.reg_address = aec_pkg::REG_EXP_LO;
          results.reg_value = exposure[7:0];
        end
        aec_pkg::WORD_HOLD_CLEAR: begin
          results.reg_address = aec_pkg::REG_HOLD;
          results.reg_value = 8'd0;
        end
        default: begin
          results.reg_address = '0;
          results.reg_value = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      is_write <= 1'b0;
      word_index <= aec_pkg::WORD_HOLD_SET;
    end else if (start) begin
      busy <= 1'b1;
      is_write <= start_write;
      word_index <= aec_pkg::WORD_HOLD_SET;
    end else if (busy && results.ready) begin
      if (word_last) begin
        busy <= 1'b0;
      end else begin
        word_index <= word_index + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/auto_exposure_controller.sv =====
// top level of the auto exposure controller
// One grid sample is taken per clock while no frame end is held, and costs no output word; it
// passes an input register and is then added into the frame statistics. A frame end gives one
// status word, or four sensor register writes when an update is due and the exposure changes,
// each word one cycle at the output when the sink is ready. A frame end is held in the input
// register until the output sequencer has delivered the last word of the previous frame end,
// and the input stalls while it is held there. The exposure update itself is computed in the
// cycle the frame end leaves the input register.
module auto_exposure_controller #(
  parameter int SAMPLE_COUNT_LOG2 = aec_pkg::SAMPLE_COUNT_LOG2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [aec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [aec_pkg::CFG_DATA_W-1:0]  cfg_data,
  aec_in_if.sink                          samples,
  aec_out_if.source                       results
);

  aec_pkg::cfg_t                       cfg;
  aec_pkg::accum_ctl_t                 accum_ctl;
  logic                                stage_valid;
  logic                                stage_action;
  logic [aec_pkg::SAMPLE_W-1:0]        stage_sample;
  logic                                stage_fire;
  logic                                frame_fire;
  logic                                can_load;
  logic [SAMPLE_COUNT_LOG2+7:0]        sum;
  logic [SAMPLE_COUNT_LOG2:0]          sat;
  logic                                update_due;
  logic [aec_pkg::EXPOSURE_W-1:0]      exposure_lines;
  logic [aec_pkg::EXPOSURE_W-1:0]      exposure_new;
  logic                                changed;
  logic                                do_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level <= aec_pkg::TARGET_LEVEL_RESET;
      cfg.black_level <= aec_pkg::BLACK_LEVEL_RESET;
      cfg.period_log2 <= aec_pkg::PERIOD_LOG2_RESET;
      cfg.exposure_min <= aec_pkg::EXPOSURE_MIN_RESET;
      cfg.exposure_max <= aec_pkg::EXPOSURE_MAX_RESET;
      cfg.saturation_level <= aec_pkg::SATURATION_LEVEL_RESET;
      cfg.saturation_max_percent <= aec_pkg::SATURATION_PCT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        aec_pkg::CFG_TARGET_LEVEL:       cfg.target_level <= cfg_data[7:0];
        aec_pkg::CFG_BLACK_LEVEL:        cfg.black_level <= cfg_data[7:0];
        aec_pkg::CFG_PERIOD_LOG2:        cfg.period_log2 <= cfg_data[2:0];
        aec_pkg::CFG_EXPOSURE_MIN:       cfg.exposure_min <= cfg_data;
        aec_pkg::CFG_EXPOSURE_MAX:       cfg.exposure_max <= cfg_data;
        aec_pkg::CFG_SATURATION_LEVEL:   cfg.saturation_level <= cfg_data[7:0];
        aec_pkg::CFG_SATURATION_MAX_PCT: cfg.saturation_max_percent <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_comb begin
    stage_fire = stage_valid && (!stage_action || can_load);
    frame_fire = stage_fire && stage_action;
    samples.ready = !stage_valid || stage_fire;
    accum_ctl.add = stage_fire && !stage_action;
    accum_ctl.frame_end = frame_fire;
    accum_ctl.sample = stage_sample;
    do_write = update_due && changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (samples.ready) begin
      stage_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      stage_action <= samples.action;
      stage_sample <= samples.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_lines <= aec_pkg::EXPOSURE_RESET;
    end else if (frame_fire && do_write) begin
      exposure_lines <= exposure_new;
    end
  end

  aec_accum #(
    .SAMPLE_COUNT_LOG2 (SAMPLE_COUNT_LOG2)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .ctl        (accum_ctl),
    .cfg        (cfg),
    .sum        (sum),
    .sat        (sat),
    .update_due (update_due)
  );

  aec_update #(
    .SAMPLE_COUNT_LOG2 (SAMPLE_COUNT_LOG2)
  ) u_update (
    .sum           (sum),
    .sat           (sat),
    .cfg           (cfg),
    .exposure      (exposure_lines),
    .exposure_next (exposure_new),
    .changed       (changed)
  );

  aec_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (frame_fire),
    .start_write (do_write),
    .exposure    (exposure_lines),
    .can_load    (can_load),
    .results     (results)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the auto exposure controller: frame statistics, exposure law and register writes
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aec_pkg::*;

  localparam int SUM_W         = SAMPLE_COUNT_LOG2 + 8;
  localparam int CNT_W         = SAMPLE_COUNT_LOG2 + 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_WORDS  = 420;
  localparam int RANDOM_FRAMES = 130;
  localparam int PHASE_FRAMES  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_FRAME_END = 1'b1;

  typedef struct packed {
    logic                  write_valid;
    logic [ADDR_W-1:0]     reg_address;
    logic [7:0]            reg_value;
    logic [EXPOSURE_W-1:0] exposure;
    logic                  last;
  } sensor_word_t;

  typedef enum logic {ROW_SETTING, ROW_FRAME} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic [11:0]            n_samples;
    logic [SAMPLE_W-1:0]    level;
    logic                   typed;
    logic                   t_write;
    logic [EXPOSURE_W-1:0]  t_exposure;
  } plan_row_t;

  localparam plan_row_t PLAN [32] = '{
    '{ROW_FRAME,   '0,                     '0,       12'd0,    8'd0,   1'b1, 1'b0, 12'd1131},
    '{ROW_FRAME,   '0,                     '0,       12'd1,    8'd0,   1'b1, 1'b0, 12'd1131},
    '{ROW_FRAME,   '0,                     '0,       12'd1,    8'd255, 1'b1, 1'b0, 12'd1131},
    '{ROW_FRAME,   '0,                     '0,       12'd3,    8'd128, 1'b1, 1'b1, 12'd1143},
    '{ROW_SETTING, CFG_PERIOD_LOG2,        12'hFF8,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd1100, 8'd255, 1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd2100, 8'd250, 1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_SATURATION_MAX_PCT, 12'hFFF,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd1024, 8'd255, 1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_BLACK_LEVEL,        12'h0FF,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_TARGET_LEVEL,       12'hF00,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd8,    8'd255, 1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_BLACK_LEVEL,        12'h000,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd8,    8'd255, 1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_SATURATION_MAX_PCT, 12'h000,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_SATURATION_LEVEL,   12'h000,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd1,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_EXPOSURE_MIN,       12'hFFF,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_EXPOSURE_MAX,       12'h000,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd0,    8'd0,   1'b1, 1'b1, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd0,    8'd0,   1'b1, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_EXPOSURE_MIN,       12'h000,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_EXPOSURE_MAX,       12'hFFF,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_TARGET_LEVEL,       12'h0FF,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_SATURATION_LEVEL,   12'h0FF,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_SETTING, CFG_SATURATION_MAX_PCT, 12'd100,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd0,    8'd0,   1'b1, 1'b1, 12'd31},
    '{ROW_SETTING, CFG_EXPOSURE_MIN,       12'hFFF,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd0,    8'd0,   1'b1, 1'b1, 12'd4095},
    '{ROW_FRAME,   '0,                     '0,       12'd0,    8'd0,   1'b1, 1'b0, 12'd4095},
    '{ROW_SETTING, CFG_UNUSED,             12'hABC,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0},
    '{ROW_FRAME,   '0,                     '0,       12'd4,    8'd255, 1'b0, 1'b0, 12'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  aec_in_if  samples_if ();
  aec_out_if results_if ();

  auto_exposure_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  cfg_t                  setting;
  logic [SUM_W-1:0]      grid_sum;
  logic [CNT_W-1:0]      clipped_count;
  logic [FRAME_W-1:0]    frame_count;
  logic [EXPOSURE_W-1:0] exposure_now;
  sensor_word_t          words_due [$];
  int                    failures = 0;
  int                    idle_cycles = 0;
  int                    words_sent = 0;
  bit                    sender_steady = 1'b0;

  always #6 clk = ~clk;

  function automatic void store_setting(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TARGET_LEVEL:       setting.target_level = data[7:0];
      CFG_BLACK_LEVEL:        setting.black_level = data[7:0];
      CFG_PERIOD_LOG2:        setting.period_log2 = data[2:0];
      CFG_EXPOSURE_MIN:       setting.exposure_min = data;
      CFG_EXPOSURE_MAX:       setting.exposure_max = data;
      CFG_SATURATION_LEVEL:   setting.saturation_level = data[7:0];
      CFG_SATURATION_MAX_PCT: setting.saturation_max_percent = data[6:0];
      default: ;
    endcase
  endfunction

  function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] value);
    logic [SUM_W:0] total;
    total = {1'b0, grid_sum} + value;
    grid_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
    if (value >= setting.saturation_level && clipped_count != '1) begin
      clipped_count = clipped_count + 1'b1;
    end
  endfunction

  // returns 1 when the exposure moved
  function automatic logic close_frame();
    int mean;
    int clipped;
    int level;
    int err;
    int step;
    int down;
    int next;
    frame_count = frame_count + 1'b1;
    mean = int'(grid_sum >> SAMPLE_COUNT_LOG2);
    clipped = int'(clipped_count);
    grid_sum = '0;
    clipped_count = '0;
    if (int'(frame_count) % (1 << setting.period_log2) != 0) return 1'b0;
    level = mean - int'(setting.black_level);
    if (level < 0) level = 0;
    err = int'(setting.target_level) - level;
    step = err >>> 3;
    if (step > STEP_LIMIT) step = STEP_LIMIT;
    if (step < -STEP_LIMIT) step = -STEP_LIMIT;
    // highlight protection
    if (clipped * PERCENT_SCALE > (int'(setting.saturation_max_percent) << SAMPLE_COUNT_LOG2)) begin
      down = -HIGHLIGHT_BASE - ((clipped * HIGHLIGHT_GAIN) >>> SAMPLE_COUNT_LOG2);
      if (down < step) step = down;
    end
    next = int'(exposure_now) + step;
    if (next < int'(setting.exposure_min)) next = int'(setting.exposure_min);
    if (next > int'(setting.exposure_max)) next = int'(setting.exposure_max);
    if (next == int'(exposure_now)) return 1'b0;
    exposure_now = EXPOSURE_W'(next);
    return 1'b1;
  endfunction

  function automatic void queue_frame_words(input logic write, input logic [EXPOSURE_W-1:0] expo);
    if (write) begin
      words_due.push_back('{1'b1, REG_HOLD, 8'd1, expo, 1'b0});
      words_due.push_back('{1'b1, REG_EXP_HI, {4'd0, expo[11:8]}, expo, 1'b0});
      words_due.push_back('{1'b1, REG_EXP_LO, expo[7:0], expo, 1'b0});
      words_due.push_back('{1'b1, REG_HOLD, 8'd0, expo, 1'b1});
    end else begin
      words_due.push_back('{1'b0, 16'd0, 8'd0, expo, 1'b1});
    end
  endfunction

  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endfunction

  task automatic offer_word(input logic action, input logic [SAMPLE_W-1:0] value);
    samples_if.valid  <= 1'b1;
    samples_if.action <= action;
    samples_if.sample <= value;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = sender_steady ? 0 : gap_cycles();
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    samples_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    store_setting(idx, data);
  endtask

  task automatic play_frame(input int count, input logic [7:0] lo, input logic [7:0] hi,
                            input logic typed, input logic t_write,
                            input logic [EXPOSURE_W-1:0] t_exposure);
    logic [SAMPLE_W-1:0] value;
    logic changed;
    repeat (count) begin
      value = SAMPLE_W'($urandom_range(lo, hi));
      offer_word(ACT_SAMPLE, value);
      accumulate_sample(value);
      pause_sender();
    end
    offer_word(ACT_FRAME_END, SAMPLE_W'($urandom()));
    changed = close_frame();
    if (typed) begin
      queue_frame_words(t_write, t_exposure);
    end else begin
      queue_frame_words(changed, exposure_now);
    end
    pause_sender();
  endtask

  task automatic shuffle_settings();
    logic [EXPOSURE_W-1:0] lo_exp;
    logic [EXPOSURE_W-1:0] hi_exp;
    logic [2:0] period;
    settle();
    lo_exp = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 800));
    hi_exp = ($urandom_range(0, 7) == 0) ? 12'($urandom()) : 12'($urandom_range(lo_exp, 4095));
    period = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
    program_reg(CFG_TARGET_LEVEL, {4'($urandom()), pick_byte()});
    program_reg(CFG_BLACK_LEVEL, {4'($urandom()),
                ($urandom_range(0, 3) == 0) ? pick_byte() : 8'($urandom_range(0, 40))});
    program_reg(CFG_PERIOD_LOG2, {9'($urandom()), period});
    program_reg(CFG_EXPOSURE_MIN, lo_exp);
    program_reg(CFG_EXPOSURE_MAX, hi_exp);
    program_reg(CFG_SATURATION_LEVEL, {4'($urandom()), pick_byte()});
    program_reg(CFG_SATURATION_MAX_PCT, {5'($urandom()), 7'($urandom_range(0, 127))});
    if ($urandom_range(0, 3) == 0) begin
      program_reg(CFG_UNUSED, 12'($urandom()));
    end
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    sensor_word_t due;
    if (!rst && results_if.valid && results_if.ready) begin
      if (words_due.size() == 0) begin
        $error("unexpected word: address %h value %h exposure %0d", results_if.reg_address,
               results_if.reg_value, results_if.exposure);
        failures++;
      end else begin
        due = words_due.pop_front();
        check_field("write_valid", due.write_valid, results_if.write_valid);
        check_field("reg_address", due.reg_address, results_if.reg_address);
        check_field("reg_value", due.reg_value, results_if.reg_value);
        check_field("exposure", due.exposure, results_if.exposure);
        check_field("last", due.last, results_if.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("auto_exposure_controller test failed");
      $finish;
    end
  end

  // sink side
  initial begin
    int run;
    int stall;
    results_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      results_if.ready <= 1'b1;
      run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      stall = gap_cycles();
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int frames;
    int count;
    logic [7:0] lo;
    logic [7:0] hi;
    samples_if.valid  = 1'b0;
    samples_if.action = ACT_SAMPLE;
    samples_if.sample = '0;
    setting = '{TARGET_LEVEL_RESET, BLACK_LEVEL_RESET, PERIOD_LOG2_RESET, EXPOSURE_MIN_RESET,
                EXPOSURE_MAX_RESET, SATURATION_LEVEL_RESET, SATURATION_PCT_RESET};
    grid_sum = '0;
    clipped_count = '0;
    frame_count = '0;
    exposure_now = EXPOSURE_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_SETTING) begin
        settle();
        program_reg(PLAN[r].index, PLAN[r].data);
        cfg_write <= 1'b0;
      end else begin
        play_frame(int'(PLAN[r].n_samples), PLAN[r].level, PLAN[r].level, PLAN[r].typed,
                   PLAN[r].t_write, PLAN[r].t_exposure);
      end
    end

    frames = 0;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS || frames < RANDOM_FRAMES) begin
      if (frames % PHASE_FRAMES == 0) begin
        shuffle_settings();
        sender_steady = ($urandom_range(0, 3) == 0);
      end else if ($urandom_range(0, 19) == 0) begin
        settle();
      end
      lo = 8'($urandom());
      hi = 8'($urandom_range(lo, 255));
      count = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 1100) : $urandom_range(0, 8);
      play_frame(count, lo, hi, 1'b0, 1'b0, '0);
      frames++;
    end

    settle();
    if (failures == 0) begin
      $display("auto_exposure_controller test passed");
    end else begin
      $display("auto_exposure_controller test failed");
    end
    $finish;
  end

endmodule
